// ===== sv/lbe_pkg.sv =====
package lbe_pkg;

  // Input item kinds, as carried on the slave tuser.
  localparam logic [2:0] KIND_CHECKED = 3'd0;
  localparam logic [2:0] KIND_DELAY   = 3'd1;
  localparam logic [2:0] KIND_HEADER  = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_BLOCK   = 3'd4;

  // Register indexes on the configuration port (word address bits).
  localparam logic [1:0] REG_SYNC_MODE      = 2'd0;
  localparam logic [1:0] REG_FAST_MODE      = 2'd1;
  localparam logic [1:0] REG_OPEN_BUS_LEVEL = 2'd2;

  localparam logic [7:0] SIGNATURE_BYTE  = 8'hd3;
  localparam logic [7:0] OPEN_BUS_RESET  = 8'd64;
  localparam logic [7:0] DELAY_RAW_BYTE  = 8'hff;
  localparam logic [8:0] CHECK_INVERT    = 9'h0ff;

  // One step of work for the back end. Every checked kind may be preceded
  // by a sync preamble byte, which the back end inserts on its own.
  typedef enum logic [2:0] {
    UOP_RAW,        // delay byte, no state change
    UOP_CHK_LIT,    // checked byte of the literal
    UOP_CHK_NCHK,   // checked byte of the inverted check (async header tail)
    UOP_CHK_SIG,    // invert the check, then checked signature literal
    UOP_CHK_PAR,    // checked byte of literal XOR check (async block parity)
    UOP_CHK_ZSETOP, // checked zero, then the check takes the literal opcode
    UOP_CHAIN,      // fast-sync payload byte through the rotate chain
    UOP_CHAIN_LAST  // as above, final byte folds the carry
  } uop_kind_t;

  typedef struct packed {
    uop_kind_t  kind;
    logic [7:0] lit;
    logic       last;
  } uop_t;

  typedef struct packed {
    logic       sync_mode;
    logic       fast_mode;
    logic [7:0] open_bus_level;
  } cfg_t;

  // Every set bit i of the level XORs 0xff << i in; the upper bits fold
  // down by nine places.
  function automatic logic [8:0] chain_mask(input logic [7:0] level);
    logic [15:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (level[i]) begin
        m = m ^ (16'h00ff << i);
      end
    end
    m = m ^ (m >> 9);
    return m[8:0];
  endfunction

  // Wire form of a byte: bit-reversed, then inverted.
  function automatic logic [7:0] wire_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7 - i] = ~v[i];
    end
    return r;
  endfunction

endpackage

// ===== sv/lbe_front.sv =====
module lbe_front (
  input  logic          clk,
  input  logic          rst,
  input  lbe_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [2:0]    in_kind,
  input  logic [7:0]    in_data,
  input  logic [7:0]    in_op,
  input  logic [15:0]   in_addr,
  input  logic [8:0]    in_len,
  input  logic          in_indexed,
  input  logic          in_is_last,
  input  logic [7:0]    in_parity,
  output logic          uop_valid,
  input  logic          uop_ready,
  output lbe_pkg::uop_t uop
);
  import lbe_pkg::*;

  logic        hold_valid;
  logic [2:0]  hold_kind;
  logic [7:0]  hold_data;
  logic [7:0]  hold_op;
  logic [15:0] hold_addr;
  logic [7:0]  hold_xlo;
  logic        hold_len_zero;
  logic        hold_is_last;
  logic [7:0]  hold_parity;
  logic [2:0]  step;

  logic [15:0] offset;
  logic [2:0]  n_steps;
  logic        done;

  // 256 - length, modulo 65536; only its low byte goes on the wire.
  assign offset = 16'd256 - {7'b0, in_len};

  always_comb begin
    n_steps  = 3'd0;
    uop.kind = UOP_CHK_LIT;
    uop.lit  = hold_data;
    case (hold_kind)
      KIND_CHECKED: begin
        n_steps = 3'd1;
      end
      KIND_DELAY: begin
        n_steps  = 3'd1;
        uop.kind = UOP_RAW;
      end
      KIND_HEADER: begin
        n_steps = hold_len_zero ? 3'd0 : 3'd5;
        case (step)
          3'd0: uop.lit = cfg.sync_mode ? hold_op : ~hold_op;
          3'd1: uop.lit = hold_addr[7:0];
          3'd2: uop.lit = hold_addr[15:8];
          3'd3: uop.lit = hold_xlo;
          default: begin
            if (!cfg.sync_mode) begin
              uop.kind = UOP_CHK_NCHK;
              uop.lit  = 8'h00;
            end else if (cfg.fast_mode && hold_op[7]) begin
              uop.kind = UOP_CHK_ZSETOP;
              uop.lit  = hold_op;
            end else begin
              uop.lit = 8'h00;
            end
          end
        endcase
      end
      KIND_PAYLOAD: begin
        n_steps = 3'd1;
        if (cfg.sync_mode && cfg.fast_mode) begin
          uop.kind = hold_is_last ? UOP_CHAIN_LAST : UOP_CHAIN;
        end
      end
      KIND_BLOCK: begin
        n_steps = cfg.sync_mode ? 3'd0 : 3'd2;
        if (step == 3'd0) begin
          uop.kind = UOP_CHK_SIG;
          uop.lit  = SIGNATURE_BYTE;
        end else begin
          uop.kind = UOP_CHK_PAR;
          uop.lit  = hold_parity;
        end
      end
      default: begin
        n_steps = 3'd0;
      end
    endcase
    uop.last = (step == n_steps - 3'd1);
  end

  assign uop_valid = hold_valid && (n_steps != 3'd0);
  assign done      = hold_valid && ((n_steps == 3'd0) || (uop_ready && uop.last));
  assign in_ready  = !hold_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      step       <= 3'd0;
    end else if (in_valid && in_ready) begin
      hold_valid    <= 1'b1;
      step          <= 3'd0;
      hold_kind     <= in_kind;
      hold_data     <= in_data;
      hold_op       <= in_op;
      hold_addr     <= in_indexed ? (in_addr - offset) : in_addr;
      hold_xlo      <= offset[7:0];
      hold_len_zero <= (in_len == 9'd0);
      hold_is_last  <= in_is_last;
      hold_parity   <= in_parity;
    end else if (done) begin
      hold_valid <= 1'b0;
    end else if (uop_valid && uop_ready) begin
      step <= step + 3'd1;
    end
  end

  a_hold_keeps_item: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !done) |=> (hold_valid && $stable(hold_kind)))
    else $error("front dropped an item before its last step was queued");

endmodule

// ===== sv/lbe_queue.sv =====
module lbe_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  lbe_pkg::uop_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output lbe_pkg::uop_t pop_data
);
  import lbe_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  uop_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + CW'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - CW'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count beyond its depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push_fire && !pop_fire) |=> (count == $past(count) + CW'(1)))
    else $error("queue fill count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop_fire && !push_fire) |=> (count == $past(count) - CW'(1)))
    else $error("queue fill count missed a pop");

endmodule

// ===== sv/lbe_back.sv =====
module lbe_back (
  input  logic          clk,
  input  logic          rst,
  input  lbe_pkg::cfg_t cfg,
  input  logic          uop_valid,
  output logic          uop_ready,
  input  lbe_pkg::uop_t uop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);
  import lbe_pkg::*;

  logic [8:0] check;
  logic       pending;

  logic       advance;
  logic       is_chk;
  logic       preamble;
  logic [8:0] mask;
  logic [8:0] c_eff;
  logic [8:0] v;
  logic [8:0] chain_word;
  logic [8:0] sync_word;
  logic [7:0] raw;
  logic       last_next;
  logic [8:0] check_next;
  logic       pending_next;

  assign advance   = !out_valid || out_ready;
  assign is_chk    = uop.kind inside {UOP_CHK_LIT, UOP_CHK_NCHK, UOP_CHK_SIG,
                                      UOP_CHK_PAR, UOP_CHK_ZSETOP};
  // In sync mode the first checked byte follows a zero (fast: mask).
  assign preamble  = is_chk && pending && cfg.sync_mode;
  assign uop_ready = advance && !preamble;
  assign mask      = chain_mask(cfg.open_bus_level);

  always_comb begin
    if (pending) begin
      c_eff = '0;
    end else if (uop.kind == UOP_CHK_NCHK || uop.kind == UOP_CHK_SIG) begin
      c_eff = check ^ CHECK_INVERT;
    end else begin
      c_eff = check;
    end

    case (uop.kind)
      UOP_CHK_NCHK:   v = check ^ CHECK_INVERT;
      UOP_CHK_PAR:    v = {1'b0, uop.lit} ^ check;
      UOP_CHK_ZSETOP: v = '0;
      default:        v = {1'b0, uop.lit};
    endcase

    chain_word = {check[1:0], check[8:2]} ^ {1'b0, uop.lit} ^ mask;
    sync_word  = cfg.fast_mode ? (v ^ mask ^ c_eff) : (v ^ c_eff);

    raw          = DELAY_RAW_BYTE;
    last_next    = uop.last;
    check_next   = check;
    pending_next = pending;

    if (preamble) begin
      raw          = cfg.fast_mode ? mask[7:0] : 8'h00;
      last_next    = 1'b0;
      check_next   = '0;
      pending_next = 1'b0;
    end else begin
      case (uop.kind)
        UOP_RAW: begin
          raw = DELAY_RAW_BYTE;
        end
        UOP_CHAIN: begin
          raw        = chain_word[7:0];
          check_next = {chain_word[8], uop.lit};
        end
        UOP_CHAIN_LAST: begin
          raw        = chain_word[7:0];
          check_next = {1'b0, uop.lit} + {8'b0, chain_word[8]};
        end
        default: begin
          pending_next = 1'b0;
          if (!cfg.sync_mode) begin
            raw        = v[7:0];
            check_next = c_eff ^ v;
          end else begin
            raw        = sync_word[7:0];
            check_next = v;
          end
          if (uop.kind == UOP_CHK_ZSETOP) begin
            check_next = {1'b0, uop.lit};
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      check     <= '0;
      pending   <= 1'b1;
    end else if (advance) begin
      out_valid <= uop_valid;
      if (uop_valid) begin
        out_byte <= wire_byte(raw);
        out_last <= last_next;
        check    <= check_next;
        pending  <= pending_next;
      end
    end
  end

  a_preamble_once: assert property (@(posedge clk) disable iff (rst)
    !pending |=> !pending)
    else $error("sync preamble armed again after the first checked byte");

  a_preamble_not_last: assert property (@(posedge clk) disable iff (rst)
    (advance && uop_valid && preamble) |=> (out_valid && !out_last))
    else $error("preamble byte was marked as the last of its item");

endmodule

// ===== sv/link_byte_encoder_unit.sv =====
// Link byte encoder: turns a stream of host-to-console command items into
// wire bytes, each one bit-reversed and inverted, in asynchronous, sync or
// sync-fast link encoding as set on the configuration port. A front stage
// takes one item per beat and expands it into byte steps, one step per cycle
// while the queue has room, into a short queue; a back stage pops one step
// per cycle unless the output stalls or a preamble goes first, applies the
// running check and the sync chain, and holds the wire byte in an output
// register, so a short stall on the output is soaked up by the queue
// before it holds up the input. Checked, delay and payload items make one
// byte step each, so a run of them streams one byte per cycle when nothing
// stalls. An operation header makes five byte steps and an asynchronous
// block start two; that expansion, one step per cycle, sets the input rate
// for them. The very first checked byte after reset in a sync mode is
// preceded by a preamble byte, which the back stage sends before it pops
// that step. Items that produce no bytes (zero length headers, block
// starts in sync mode, unknown kinds) leave the front with no byte step.
// Configuration should be written only while no bytes are in flight.
module link_byte_encoder_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input item stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0: data_byte[7:0], op_code[15:8], address[31:16],
  // length[40:32], indexed[41], block_parity[49:42], zero pad[55:50].
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // is_last
  input  logic [2:0]  s_axis_tuser,   // kind
  // Wire byte stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,   // last_of_run
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lbe_pkg::*;

  cfg_t cfg;
  logic uop_in_valid;
  logic uop_in_ready;
  uop_t uop_in;
  logic uop_out_valid;
  logic uop_out_ready;
  uop_t uop_out;
  logic cfg_write;

  // The port never stalls, and a write lands in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_mode      <= 1'b0;
      cfg.fast_mode      <= 1'b0;
      cfg.open_bus_level <= OPEN_BUS_RESET;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_SYNC_MODE:      cfg.sync_mode      <= pwdata[0];
        REG_FAST_MODE:      cfg.fast_mode      <= pwdata[0];
        REG_OPEN_BUS_LEVEL: cfg.open_bus_level <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SYNC_MODE:      prdata = {31'b0, cfg.sync_mode};
      REG_FAST_MODE:      prdata = {31'b0, cfg.fast_mode};
      REG_OPEN_BUS_LEVEL: prdata = {24'b0, cfg.open_bus_level};
      default:            prdata = '0;
    endcase
  end

  // Front: takes the item and lays out its byte steps.
  lbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_kind    (s_axis_tuser),
    .in_data    (s_axis_tdata[7:0]),
    .in_op      (s_axis_tdata[15:8]),
    .in_addr    (s_axis_tdata[31:16]),
    .in_len     (s_axis_tdata[40:32]),
    .in_indexed (s_axis_tdata[41]),
    .in_is_last (s_axis_tlast),
    .in_parity  (s_axis_tdata[49:42]),
    .uop_valid  (uop_in_valid),
    .uop_ready  (uop_in_ready),
    .uop        (uop_in)
  );

  // Queue of byte steps between the two stages.
  lbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (uop_in_valid),
    .push_ready (uop_in_ready),
    .push_data  (uop_in),
    .pop_valid  (uop_out_valid),
    .pop_ready  (uop_out_ready),
    .pop_data   (uop_out)
  );

  // Back: owns the running check and the preamble flag, and produces the
  // wire bytes into the output register.
  lbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .uop_valid (uop_out_valid),
    .uop_ready (uop_out_ready),
    .uop       (uop_out),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
